### hdl/ssi_pkg.sv
// Shared types and constants for the segment/sphere intersection test.
package ssi_pkg;

	localparam int COORD_BITS   = 16;
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int RSQ_W        = 2 * (COORD_BITS - 1);
	localparam int SUM_W        = PROD_W + 2;
	localparam int MUL_W        = 2 * SUM_W;
	localparam int DISC_W       = MUL_W + 1;
	localparam int ROOT_W       = SUM_W;
	localparam int RAD_W        = 2 * ROOT_W;
	localparam int REM_W        = ROOT_W + 3;
	localparam int TEST_W       = SUM_W + 2;
	localparam int FRONT_STAGES = 5;
	localparam int LATENCY      = FRONT_STAGES + ROOT_W + 1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic signed [COORD_BITS-1:0] center_z;
		logic [COORD_BITS-2:0]        sphere_radius;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] start_z;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic signed [COORD_BITS-1:0] end_z;
	} query_t;

	typedef struct packed {
		logic hit;
		logic degenerate;
	} result_t;

	typedef struct packed {
		logic                    degen;
		logic                    neg;
		logic signed [SUM_W-1:0] neg_b;
		logic signed [SUM_W-1:0] a;
	} side_t;

	typedef struct packed {
		logic              valid;
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		side_t             side;
	} cell_t;

endpackage

### hdl/ssi_front.sv
// Front pipeline: differences, dot products, discriminant.
module ssi_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  ssi_pkg::query_t query,
	output ssi_pkg::cell_t  cell_out
);

	logic signed [ssi_pkg::DIFF_W-1:0] l_s1 [3];
	logic signed [ssi_pkg::DIFF_W-1:0] d_s1 [3];
	logic [ssi_pkg::COORD_BITS-2:0]    r_s1;
	logic signed [ssi_pkg::PROD_W-1:0] ll_s2 [3];
	logic signed [ssi_pkg::PROD_W-1:0] dl_s2 [3];
	logic signed [ssi_pkg::PROD_W-1:0] dd_s2 [3];
	logic [ssi_pkg::RSQ_W-1:0]         rr_s2;
	logic signed [ssi_pkg::SUM_W-1:0]  a_s3, b_s3, c_s3;
	logic signed [ssi_pkg::SUM_W-1:0]  a_s4, b_s4;
	logic signed [ssi_pkg::MUL_W-1:0]  bb_s4, ac_s4;
	logic [3:0]                        vld_q;
	logic signed [ssi_pkg::DISC_W-1:0] disc;
	logic signed [ssi_pkg::COORD_BITS-1:0] p0 [3];
	logic signed [ssi_pkg::COORD_BITS-1:0] p1 [3];
	logic signed [ssi_pkg::COORD_BITS-1:0] ctr [3];

	assign p0  = '{query.start_x, query.start_y, query.start_z};
	assign p1  = '{query.end_x, query.end_y, query.end_z};
	assign ctr = '{query.center_x, query.center_y, query.center_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], take};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			l_s1[i]  <= ssi_pkg::DIFF_W'(p1[i]) - ssi_pkg::DIFF_W'(p0[i]);
			d_s1[i]  <= ssi_pkg::DIFF_W'(p0[i]) - ssi_pkg::DIFF_W'(ctr[i]);
			ll_s2[i] <= l_s1[i] * l_s1[i];
			dl_s2[i] <= d_s1[i] * l_s1[i];
			dd_s2[i] <= d_s1[i] * d_s1[i];
		end
		r_s1  <= query.sphere_radius;
		rr_s2 <= r_s1 * r_s1;
		a_s3  <= ssi_pkg::SUM_W'(ll_s2[0]) + ssi_pkg::SUM_W'(ll_s2[1])
			+ ssi_pkg::SUM_W'(ll_s2[2]);
		b_s3  <= ssi_pkg::SUM_W'(dl_s2[0]) + ssi_pkg::SUM_W'(dl_s2[1])
			+ ssi_pkg::SUM_W'(dl_s2[2]);
		c_s3  <= ssi_pkg::SUM_W'(dd_s2[0]) + ssi_pkg::SUM_W'(dd_s2[1])
			+ ssi_pkg::SUM_W'(dd_s2[2]) - signed'(ssi_pkg::SUM_W'(rr_s2));
		a_s4  <= a_s3;
		b_s4  <= b_s3;
		bb_s4 <= b_s3 * b_s3;
		ac_s4 <= a_s3 * c_s3;
	end

	assign disc = ssi_pkg::DISC_W'(bb_s4) - ssi_pkg::DISC_W'(ac_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_out <= '0;
		end else begin
			cell_out.valid      <= vld_q[3];
			cell_out.rad        <= disc[ssi_pkg::DISC_W-1] ? '0 : disc[ssi_pkg::RAD_W-1:0];
			cell_out.rem        <= '0;
			cell_out.root       <= '0;
			cell_out.side.degen <= (a_s4 == '0);
			cell_out.side.neg   <= disc[ssi_pkg::DISC_W-1];
			cell_out.side.neg_b <= -b_s4;
			cell_out.side.a     <= a_s4;
		end
	end

endmodule

### hdl/ssi_cell.sv
// One square root cell: resolves one root bit and hands on to the next cell.
module ssi_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  ssi_pkg::cell_t cell_in,
	output ssi_pkg::cell_t cell_out
);

	logic [ssi_pkg::REM_W-1:0] rem_sh;
	logic [ssi_pkg::REM_W-1:0] trial;
	logic                      fits;

	assign rem_sh = {cell_in.rem[ssi_pkg::REM_W-3:0],
		cell_in.rad[ssi_pkg::RAD_W-1:ssi_pkg::RAD_W-2]};
	assign trial  = ssi_pkg::REM_W'({cell_in.root, 2'b01});
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_out <= '0;
		end else begin
			cell_out.valid <= cell_in.valid;
			cell_out.rad   <= {cell_in.rad[ssi_pkg::RAD_W-3:0], 2'b00};
			cell_out.rem   <= fits ? (rem_sh - trial) : rem_sh;
			cell_out.root  <= {cell_in.root[ssi_pkg::ROOT_W-2:0], fits};
			cell_out.side  <= cell_in.side;
		end
	end

endmodule

### hdl/segment_sphere_intersect.sv
// Top level of the segment versus sphere intersection test.
//
// Use: present a query word on query and raise start; the word is taken at
// every rising edge where start is high and busy is low. busy never rises, so
// a new query may enter on every cycle, one word per cycle sustained.
// Each query yields exactly one result word on result, shown for a single
// cycle with done high, in query order. The path runs through the front
// pipeline (five stages: differences, products, sums, products of the sums,
// discriminant), then the square root chain with one cell per root bit
// (SUM_W cells), then one register for the range test.
// hit is 1 when a crossing parameter lies in [0,1]; degenerate flags a
// zero-length segment, and then hit is forced to 1.
// The receiver cannot hold results off: take them in the cycle done is high.
// Reset clears all valid flags at once; in-flight queries are dropped and
// no result appears until new queries are taken.
module segment_sphere_intersect (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ssi_pkg::query_t  query,
	output logic             done,
	output ssi_pkg::result_t result
);

	ssi_pkg::cell_t chain [ssi_pkg::ROOT_W+1];

	logic signed [ssi_pkg::TEST_W-1:0] t_hi, t_lo, a_ext;
	logic                              in_hi, in_lo;
	ssi_pkg::side_t                    last;

	// Never stall the input side.
	assign busy = 1'b0;

	ssi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (start && !busy),
		.query    (query),
		.cell_out (chain[0])
	);

	// Square root chain, most significant root bit first.
	for (genvar g = 0; g < ssi_pkg::ROOT_W; g++) begin : g_cell
		ssi_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_in  (chain[g]),
			.cell_out (chain[g+1])
		);
	end

	assign last  = chain[ssi_pkg::ROOT_W].side;
	assign a_ext = ssi_pkg::TEST_W'(last.a);
	// Check both roots -B+s and -B-s against [0, A].
	assign t_hi  = ssi_pkg::TEST_W'(last.neg_b)
		+ ssi_pkg::TEST_W'({1'b0, chain[ssi_pkg::ROOT_W].root});
	assign t_lo  = ssi_pkg::TEST_W'(last.neg_b)
		- ssi_pkg::TEST_W'({1'b0, chain[ssi_pkg::ROOT_W].root});
	assign in_hi = !t_hi[ssi_pkg::TEST_W-1] && (t_hi <= a_ext);
	assign in_lo = !t_lo[ssi_pkg::TEST_W-1] && (t_lo <= a_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= chain[ssi_pkg::ROOT_W].valid;
		end
	end

	// Zero-length segment wins over everything; a negative discriminant misses.
	always_ff @(posedge clk) begin
		result.degenerate <= last.degen;
		result.hit        <= last.degen || (!last.neg && (in_hi || in_lo));
	end

endmodule

### hdl/ssi_checker.sv
// Port-level checker for the intersection test, bound to the top level.
module ssi_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input ssi_pkg::query_t  query,
	input logic             done,
	input ssi_pkg::result_t result
);

	logic zero_len;

	assign zero_len = (query.start_x == query.end_x) && (query.start_y == query.end_y)
		&& (query.start_z == query.end_z);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_degen_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.degenerate) |-> result.hit)
		else $error("degenerate result without hit");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(ssi_pkg::LATENCY) done)
		else $error("result word missing");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && zero_len) |-> ##(ssi_pkg::LATENCY) (done && result.degenerate))
		else $error("zero-length segment not flagged");

endmodule

bind segment_sphere_intersect ssi_checker u_ssi_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.query  (query),
	.done   (done),
	.result (result)
);

### bench/tb.sv
// Testbench for the segment versus sphere intersection test.
`timescale 1ns / 1ps

module tb;

	localparam int MAX_CYCLES = 400000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	ssi_pkg::query_t  query = '0;
	logic             done;
	ssi_pkg::result_t result;

	int sender_idle = 0;   // percent of cycles the sender sits idle
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int hits_seen = 0;
	int degen_seen = 0;
	longint cycle_count = 0;
	ssi_pkg::result_t hit_queue[$];

	segment_sphere_intersect dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.query(query), .done(done), .result(result)
	);

	always #4 clk = ~clk;

	// Predict hit and degenerate flags; 192-bit signed math keeps everything exact.
	function automatic ssi_pkg::result_t predict_hit(ssi_pkg::query_t q);
		logic signed [191:0] lx, ly, lz, dx, dy, dz, a, b, c, disc, s, nb, t0, t1, cand;
		ssi_pkg::result_t r;
		lx = 192'(signed'(q.end_x)) - 192'(signed'(q.start_x));
		ly = 192'(signed'(q.end_y)) - 192'(signed'(q.start_y));
		lz = 192'(signed'(q.end_z)) - 192'(signed'(q.start_z));
		dx = 192'(signed'(q.start_x)) - 192'(signed'(q.center_x));
		dy = 192'(signed'(q.start_y)) - 192'(signed'(q.center_y));
		dz = 192'(signed'(q.start_z)) - 192'(signed'(q.center_z));
		a = lx*lx + ly*ly + lz*lz;
		b = dx*lx + dy*ly + dz*lz;
		c = dx*dx + dy*dy + dz*dz - 192'(q.sphere_radius) * 192'(q.sphere_radius);
		r = '0;
		if (a == 0) begin
			r.hit = 1'b1;
			r.degenerate = 1'b1;
			return r;
		end
		disc = b*b - a*c;
		if (disc < 0) return r;
		s = 0;
		for (int k = 94; k >= 0; k--) begin
			cand = s | (192'(1) << k);
			if (cand*cand <= disc) s = cand;
		end
		nb = -b;
		t0 = nb + s;
		t1 = nb - s;
		r.hit = (t0 >= 0 && t0 <= a) || (t1 >= 0 && t1 <= a);
		return r;
	endfunction

	// Send one query word: drive at the falling edge, hold until taken.
	task automatic send_query(ssi_pkg::query_t q);
		while ($urandom_range(99) < sender_idle) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		query <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		hit_queue.insert(hit_queue.size(), predict_hit(q));
		words_sent++;
		@(negedge clk);
	endtask

	// Compare each result word with the oldest prediction.
	always @(posedge clk) begin
		ssi_pkg::result_t exp_r;
		cycle_count++;
		if (arst_n && done) begin
			if (hit_queue.size() == 0) begin
				$display("%0t: unexpected result word %b", $time, result);
				errors++;
			end else begin
				exp_r = hit_queue.pop_front();
				words_checked++;
				if (result.hit) hits_seen++;
				if (result.degenerate) degen_seen++;
				if (result.hit !== exp_r.hit) begin
					$display("%0t: hit expected %b actual %b", $time, exp_r.hit, result.hit);
					errors++;
				end
				if (result.degenerate !== exp_r.degenerate) begin
					$display("%0t: degenerate expected %b actual %b", $time,
						exp_r.degenerate, result.degenerate);
					errors++;
				end
			end
		end
		if (cycle_count > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic ssi_pkg::query_t make_query(int cx, int cy, int cz, int r,
			int sx, int sy, int sz, int ex, int ey, int ez);
		ssi_pkg::query_t q;
		q.center_x = ssi_pkg::COORD_BITS'(cx);
		q.center_y = ssi_pkg::COORD_BITS'(cy);
		q.center_z = ssi_pkg::COORD_BITS'(cz);
		q.sphere_radius = (ssi_pkg::COORD_BITS-1)'(r);
		q.start_x = ssi_pkg::COORD_BITS'(sx);
		q.start_y = ssi_pkg::COORD_BITS'(sy);
		q.start_z = ssi_pkg::COORD_BITS'(sz);
		q.end_x = ssi_pkg::COORD_BITS'(ex);
		q.end_y = ssi_pkg::COORD_BITS'(ey);
		q.end_z = ssi_pkg::COORD_BITS'(ez);
		return q;
	endfunction

	// Extremes, zero-length, inside, tangent, miss and crossing cases.
	task automatic test_directed();
		send_query(make_query(0, 0, 0, 10, -20, 0, 0, 20, 0, 0));
		send_query(make_query(0, 0, 0, 10, 5, 5, 5, 5, 5, 5));
		send_query(make_query(0, 0, 0, 100, -5, 0, 0, 5, 0, 0));
		send_query(make_query(0, 0, 0, 10, -20, 10, 0, 20, 10, 0));
		send_query(make_query(0, 0, 0, 10, -20, 11, 0, 20, 11, 0));
		send_query(make_query(0, 0, 0, 10, 0, 0, 0, 30, 0, 0));
		send_query(make_query(0, 0, 0, 10, 20, 0, 0, 40, 0, 0));
		send_query(make_query(0, 0, 0, 0, -1, 0, 0, 1, 0, 0));
		send_query(make_query(0, 0, 0, 0, 1, 1, 1, 2, 2, 2));
		send_query(make_query(-32768, -32768, -32768, 32767,
			32767, 32767, 32767, -32768, -32768, -32768));
		send_query(make_query(32767, 32767, 32767, 32767,
			-32768, -32768, -32768, -32768, -32768, -32768));
		send_query(make_query(-32768, 32767, -32768, 0,
			32767, -32768, 32767, 32767, -32768, 32767));
		send_query(make_query(0, 0, 0, 32767, -32768, -32768, -32768,
			32767, 32767, 32767));
		send_query(make_query(32767, -32768, 0, 1, 32767, -32768, 0, 32767, -32768, 1));
		send_query(make_query(0, 0, 0, 5, 3, 4, 0, 10, 4, 0));
		send_query(make_query(0, 0, 0, 5, 10, 4, 0, 3, 4, 0));
	endtask

	function automatic int rnd_coord(int base, int span);
		int v;
		v = base + $urandom_range(2 * span) - span;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	// Random queries: mostly segments near the sphere, some fully random words.
	task automatic test_random(int count);
		ssi_pkg::query_t q;
		int cx, cy, cz, r, span;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0) begin
				q = ($bits(ssi_pkg::query_t))'({$urandom, $urandom, $urandom, $urandom,
					$urandom});
				if ($urandom_range(7) == 0) begin
					q.end_x = q.start_x; q.end_y = q.start_y; q.end_z = q.start_z;
				end
			end else begin
				span = ($urandom_range(1)) ? 64 : 32767;
				cx = $urandom_range(65535) - 32768;
				cy = $urandom_range(65535) - 32768;
				cz = $urandom_range(65535) - 32768;
				r = $urandom_range(span);
				q = make_query(cx, cy, cz, r,
					rnd_coord(cx, 2 * span), rnd_coord(cy, 2 * span), rnd_coord(cz, 2 * span),
					rnd_coord(cx, 2 * span), rnd_coord(cy, 2 * span), rnd_coord(cz, 2 * span));
			end
			send_query(q);
		end
	endtask

	// Drop start and hold the sender until every outstanding result is back.
	task automatic drain_results();
		start <= 1'b0;
		while (hit_queue.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sender_idle = 0;
		test_directed();
		drain_results();
		@(negedge clk);
		test_random(600);
		sender_idle = 76;
		test_random(500);
		drain_results();
		@(negedge clk);
		sender_idle = 33;
		test_random(400);
		sender_idle = 0;
		test_random(500);

		drain_results();
		repeat (ssi_pkg::LATENCY + 10) @(posedge clk);
		$display("sent %0d queries, checked %0d results (%0d hits, %0d zero-length)",
			words_sent, words_checked, hits_seen, degen_seen);
		if (errors == 0 && hit_queue.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### segment_sphere_intersect.f
hdl/ssi_pkg.sv
hdl/ssi_front.sv
hdl/ssi_cell.sv
hdl/segment_sphere_intersect.sv
hdl/ssi_checker.sv
bench/tb.sv
